// File: rtl/core/tick_driven_dual_clock_defines.svh
// Assertion macros for the tick driven dual clock block.
// Taken in by the top level with `include; depends on nothing else.
`ifndef TICK_DRIVEN_DUAL_CLOCK_DEFINES_SVH
`define TICK_DRIVEN_DUAL_CLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TDC_ASSERT_IMP(LABEL, CLK, RST_N, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error("tdc same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TDC_ASSERT_NXT(LABEL, CLK, RST_N, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error("tdc next-cycle check failed");

`endif

// File: rtl/core/tdc_pkg.sv
// Shared types and constants for the tick driven dual clock block.
// No dependencies; used by the top level, controller, datapath and divider.
`default_nettype none

package tdc_pkg;

    localparam int unsigned HZ_W     = 30;
    localparam int unsigned NS_W     = 30;
    localparam int unsigned SEC_W    = 64;
    localparam int unsigned CNT_W    = 24;
    localparam int unsigned PERIOD_W = 20;   // 1e9 / 1000 fits in 20 bits

    localparam int unsigned COUNTER_BITS   = 24;
    localparam int unsigned TICK_PERIOD_NS = 1000000;

    // ticks per second; counts per tick are hz / TICK_DIV
    localparam int unsigned TICK_DIV = 1000000000 / TICK_PERIOD_NS;

    localparam logic [NS_W-1:0] NS_PER_SEC  = NS_W'(1000000000);
    localparam logic [HZ_W-1:0] HZ_MIN      = HZ_W'(1000);
    localparam logic [HZ_W-1:0] HZ_MAX      = HZ_W'(1000000000);
    localparam logic [HZ_W-1:0] HZ_RESET    = HZ_W'(84000000);
    localparam logic [NS_W-1:0] TICK_NS     = NS_W'(TICK_PERIOD_NS);
    localparam logic [HZ_W-1:0] TICK_HZ     = HZ_W'(TICK_DIV);

    // Divide by TICK_DIV as a multiply by a rounded-up reciprocal and a shift.
    // With the shift at HZ_W + clog2(TICK_DIV) the quotient is exact for any
    // HZ_W-bit dividend.
    localparam int unsigned RECIP_SHIFT = HZ_W + $clog2(TICK_DIV);
    localparam int unsigned RECIP_W     = HZ_W + 1;
    localparam logic [RECIP_W-1:0] TICK_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICK_DIV) - 64'd1) / 64'(TICK_DIV));

    localparam logic [CNT_W-1:0] CNT_MASK = (COUNTER_BITS >= CNT_W) ? {CNT_W{1'b1}} :
        CNT_W'((64'd1 << COUNTER_BITS) - 64'd1);

    localparam int unsigned DIV_STEPS = HZ_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_READ = 2'd1,
        CMD_SET  = 2'd2,
        CMD_RES  = 2'd3
    } cmd_t;

    localparam logic [1:0] SEL_MONO = 2'd0;
    localparam logic [1:0] SEL_REAL = 2'd1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_INVAL = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_CORE_CLOCK_HZ = 1'b0;

    typedef struct packed {
        logic div_start;
        logic lat_period;
        logic lat_tick;
        logic load_in;
        logic mul_en;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/tdc_if.sv
// Request and response channel interfaces for the tick driven dual clock.
// Valid/ready handshake with payload; no dependencies.
`default_nettype none

interface tdc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [1:0]         clock_select;
    logic signed [63:0] new_seconds;
    logic signed [31:0] new_nanoseconds;
    logic [23:0]        counter_now;

    modport source (
        output valid, cmd, clock_select, new_seconds, new_nanoseconds, counter_now,
        input  ready
    );
    modport sink (
        input  valid, cmd, clock_select, new_seconds, new_nanoseconds, counter_now,
        output ready
    );
endinterface

interface tdc_rsp_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [63:0] seconds_out;
    logic [29:0]        nanoseconds_out;

    modport source (
        output valid, status, seconds_out, nanoseconds_out,
        input  ready
    );
    modport sink (
        input  valid, status, seconds_out, nanoseconds_out,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/tick_driven_dual_clock.sv
// Top level of the tick driven dual clock: APB register, controller and
// datapath. Depends on tdc_pkg, tdc_if, tdc_ctrl, tdc_datapath and the defines header.
//
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------
//  req     | in  | cmd, clock_select, new_seconds, new_nanoseconds, counter_now
//  rsp     | out | status, seconds_out, nanoseconds_out
//  apb     | in  | write/read of core_clock_hz at byte address 0
//
// A transaction steps through accept, multiply of elapsed counts by the
// clock period, then add/normalize into the result register.
// After reset and after every core_clock_hz write the serial divider derives
// the clock period and a reciprocal multiply gives the counts per tick:
// req.ready stays low until both are latched (one 30-step division plus sequencing).
// A result waiting in rsp holds only the finish step; the next transaction
// is still accepted and multiplied meanwhile.
`default_nettype none
`include "tick_driven_dual_clock_defines.svh"

module tick_driven_dual_clock (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdc_req_if.sink     req,
    tdc_rsp_if.source   rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    tdc_pkg::ctrl_cmd_t        ctrl;
    tdc_pkg::dp_status_t       stat;
    logic                      cfg_wr;
    logic                      reg_hit;
    logic [tdc_pkg::HZ_W-1:0]  core_clock_hz;
    logic                      in_ready;
    logic                      out_valid;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == tdc_pkg::REG_CORE_CLOCK_HZ);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? 32'(core_clock_hz) : 32'd0;

    tdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tdc_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .stat               (stat),
        .cfg_wr             (cfg_wr),
        .cfg_data           (pwdata[tdc_pkg::HZ_W-1:0]),
        .core_clock_hz      (core_clock_hz),
        .in_cmd             (req.cmd),
        .in_clock_select    (req.clock_select),
        .in_new_seconds     (req.new_seconds),
        .in_new_nanoseconds (req.new_nanoseconds),
        .in_counter_now     (req.counter_now),
        .out_status         (rsp.status),
        .out_seconds        (rsp.seconds_out),
        .out_nanoseconds    (rsp.nanoseconds_out)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    `TDC_ASSERT_NXT(a_cfg_recompute, clk, rst_n, cfg_wr, !req.ready)
    `TDC_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready)
    `TDC_ASSERT_IMP(a_ns_normalized, clk, rst_n, rsp.valid, rsp.nanoseconds_out < tdc_pkg::NS_PER_SEC)
    `TDC_ASSERT_IMP(a_inval_zero, clk, rst_n, rsp.valid && rsp.status, (rsp.seconds_out == 64'sd0) && (rsp.nanoseconds_out == 30'd0))

endmodule

`default_nettype wire

// File: rtl/core/tdc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tdc_pkg for widths.
`default_nettype none

module tdc_divider (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [tdc_pkg::HZ_W-1:0] dividend,
    input  wire logic [tdc_pkg::HZ_W-1:0] divisor,
    output logic                         done,
    output logic [tdc_pkg::HZ_W-1:0]     quotient
);

    logic [tdc_pkg::HZ_W-1:0]      rem_reg, rem_next;
    logic [tdc_pkg::HZ_W-1:0]      quo_reg, quo_next;
    logic [tdc_pkg::HZ_W-1:0]      dsr_reg;
    logic [tdc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [tdc_pkg::HZ_W:0]        trial;
    logic                          fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tdc_pkg::HZ_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? tdc_pkg::HZ_W'(trial - {1'b0, dsr_reg})
                        : trial[tdc_pkg::HZ_W-1:0];
        quo_next = {quo_reg[tdc_pkg::HZ_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tdc_pkg::DIV_CNT_W'(tdc_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tdc_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/tdc_datapath.sv
// Datapath: clock state, config register, derived periods, multiply and
// normalize stages, result registers. Depends on tdc_pkg and tdc_divider.
`default_nettype none

module tdc_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tdc_pkg::ctrl_cmd_t           ctrl,
    output tdc_pkg::dp_status_t               stat,
    input  wire logic                         cfg_wr,
    input  wire logic [tdc_pkg::HZ_W-1:0]     cfg_data,
    output logic [tdc_pkg::HZ_W-1:0]          core_clock_hz,
    input  wire logic [1:0]                   in_cmd,
    input  wire logic [1:0]                   in_clock_select,
    input  wire logic signed [63:0]           in_new_seconds,
    input  wire logic signed [31:0]           in_new_nanoseconds,
    input  wire logic [tdc_pkg::CNT_W-1:0]    in_counter_now,
    output logic                              out_status,
    output logic signed [63:0]                out_seconds,
    output logic [tdc_pkg::NS_W-1:0]          out_nanoseconds
);

    localparam int unsigned HZ_W     = tdc_pkg::HZ_W;
    localparam int unsigned NS_W     = tdc_pkg::NS_W;
    localparam int unsigned SEC_W    = tdc_pkg::SEC_W;
    localparam int unsigned PERIOD_W = tdc_pkg::PERIOD_W;
    localparam int unsigned PROD_W   = HZ_W + PERIOD_W;
    localparam int unsigned TPROD_W  = HZ_W + tdc_pkg::RECIP_W;

    // configuration and derived values
    logic [HZ_W-1:0]     hz_reg;
    logic [HZ_W-1:0]     eff_hz;
    logic [PERIOD_W-1:0] period_reg;
    logic [HZ_W-1:0]     per_tick_reg;
    logic                div_done;
    logic [HZ_W-1:0]     div_quo;
    logic [TPROD_W-1:0]  tick_prod;

    // clock state
    logic [SEC_W-1:0] mono_s_reg, real_s_reg;
    logic [NS_W-1:0]  mono_ns_reg, real_ns_reg;

    // captured transaction
    tdc_pkg::cmd_t            cmd_reg;
    logic [1:0]               sel_reg;
    logic [SEC_W-1:0]         nsec_reg;
    logic [31:0]              nns_reg;
    logic [tdc_pkg::CNT_W-1:0] cnt_reg;
    logic [NS_W-1:0]          prod_reg;

    // output payload
    logic             status_reg, status_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [NS_W-1:0]  ns_reg, ns_next;

    logic [HZ_W-1:0]   ticks;
    logic [PROD_W-1:0] prod_full;

    logic [SEC_W-1:0] sel_s;
    logic [NS_W-1:0]  sel_ns;
    logic [NS_W:0]    sum;
    logic             sum_carry;
    logic [NS_W:0]    mono_adv, real_adv;
    logic             mono_carry, real_carry;
    logic [NS_W-1:0]  mono_ns_next, real_ns_next;
    logic             sel_ok;
    logic             set_ok;

    assign eff_hz = (hz_reg < tdc_pkg::HZ_MIN) ? tdc_pkg::HZ_MIN :
                    (hz_reg > tdc_pkg::HZ_MAX) ? tdc_pkg::HZ_MAX : hz_reg;

    tdc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (tdc_pkg::NS_PER_SEC),
        .divisor  (eff_hz),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign stat.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg      <= tdc_pkg::HZ_RESET;
            mono_s_reg  <= '0;
            mono_ns_reg <= '0;
            real_s_reg  <= '0;
            real_ns_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                hz_reg <= cfg_data;
            end
            if (ctrl.finish && (cmd_reg == tdc_pkg::CMD_TICK))
            begin
                mono_s_reg  <= mono_s_reg + SEC_W'(mono_carry);
                mono_ns_reg <= mono_ns_next;
                real_s_reg  <= real_s_reg + SEC_W'(real_carry);
                real_ns_reg <= real_ns_next;
            end
            else if (ctrl.finish && (cmd_reg == tdc_pkg::CMD_SET) && set_ok)
            begin
                real_s_reg  <= nsec_reg;
                real_ns_reg <= nns_reg[NS_W-1:0];
            end
        end
    end

    // elapsed part of the current tick period, saturating at zero
    always_comb
    begin
        ticks     = (HZ_W'(cnt_reg) < per_tick_reg) ? (per_tick_reg - HZ_W'(cnt_reg)) : '0;
        prod_full = PROD_W'(ticks) * PROD_W'(period_reg);
        // counts per tick: clamped frequency times the reciprocal of the tick rate
        tick_prod = TPROD_W'(eff_hz) * TPROD_W'(tdc_pkg::TICK_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lat_period)
        begin
            period_reg <= div_quo[PERIOD_W-1:0];
        end
        if (ctrl.lat_tick)
        begin
            per_tick_reg <= HZ_W'(tick_prod >> tdc_pkg::RECIP_SHIFT);
        end
        if (ctrl.load_in)
        begin
            cmd_reg  <= tdc_pkg::cmd_t'(in_cmd);
            sel_reg  <= in_clock_select;
            nsec_reg <= $unsigned(in_new_seconds);
            nns_reg  <= $unsigned(in_new_nanoseconds);
            cnt_reg  <= in_counter_now & tdc_pkg::CNT_MASK;
        end
        if (ctrl.mul_en)
        begin
            // product never exceeds one tick period, so it fits below 1e9
            prod_reg <= prod_full[NS_W-1:0];
        end
        if (ctrl.finish)
        begin
            status_reg <= status_next;
            sec_reg    <= sec_next;
            ns_reg     <= ns_next;
        end
    end

    always_comb
    begin
        sel_s  = (sel_reg == tdc_pkg::SEL_MONO) ? mono_s_reg : real_s_reg;
        sel_ns = (sel_reg == tdc_pkg::SEL_MONO) ? mono_ns_reg : real_ns_reg;
        sum       = {1'b0, sel_ns} + {1'b0, prod_reg};
        sum_carry = sum >= {1'b0, tdc_pkg::NS_PER_SEC};

        mono_adv     = {1'b0, mono_ns_reg} + {1'b0, tdc_pkg::TICK_NS};
        mono_carry   = mono_adv >= {1'b0, tdc_pkg::NS_PER_SEC};
        mono_ns_next = mono_carry ? NS_W'(mono_adv - {1'b0, tdc_pkg::NS_PER_SEC})
                                  : mono_adv[NS_W-1:0];
        real_adv     = {1'b0, real_ns_reg} + {1'b0, tdc_pkg::TICK_NS};
        real_carry   = real_adv >= {1'b0, tdc_pkg::NS_PER_SEC};
        real_ns_next = real_carry ? NS_W'(real_adv - {1'b0, tdc_pkg::NS_PER_SEC})
                                  : real_adv[NS_W-1:0];

        sel_ok = sel_reg inside {tdc_pkg::SEL_MONO, tdc_pkg::SEL_REAL};
        set_ok = (sel_reg == tdc_pkg::SEL_REAL) && (nns_reg < 32'(tdc_pkg::NS_PER_SEC));

        status_next = tdc_pkg::STATUS_OK;
        sec_next    = '0;
        ns_next     = '0;
        case (cmd_reg)
            tdc_pkg::CMD_TICK:
            begin
                status_next = tdc_pkg::STATUS_OK;
            end
            tdc_pkg::CMD_READ:
            begin
                if (!sel_ok)
                begin
                    status_next = tdc_pkg::STATUS_INVAL;
                end
                else
                begin
                    sec_next = sel_s + SEC_W'(sum_carry);
                    ns_next  = sum_carry ? NS_W'(sum - {1'b0, tdc_pkg::NS_PER_SEC})
                                         : sum[NS_W-1:0];
                end
            end
            tdc_pkg::CMD_SET:
            begin
                status_next = set_ok ? tdc_pkg::STATUS_OK : tdc_pkg::STATUS_INVAL;
            end
            tdc_pkg::CMD_RES:
            begin
                if (!sel_ok)
                begin
                    status_next = tdc_pkg::STATUS_INVAL;
                end
                else
                begin
                    ns_next = NS_W'(period_reg);
                end
            end
            default:
            begin
                status_next = tdc_pkg::STATUS_INVAL;
            end
        endcase
    end

    assign core_clock_hz   = hz_reg;
    assign out_status      = status_reg;
    assign out_seconds     = $signed(sec_reg);
    assign out_nanoseconds = ns_reg;

endmodule

`default_nettype wire

// File: rtl/core/tdc_ctrl.sv
// Controller: sequences the period division after reset or a register
// write, then steps each transaction through multiply and finish.
// Depends on tdc_pkg.
`default_nettype none

module tdc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire tdc_pkg::dp_status_t stat,
    output tdc_pkg::ctrl_cmd_t       ctrl
);

    typedef enum logic [2:0] {
        ST_DIV_PERIOD,
        ST_WAIT_PERIOD,
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ctrl.div_start  = (state_reg == ST_DIV_PERIOD);
        ctrl.lat_period = (state_reg == ST_WAIT_PERIOD) && stat.div_done;
        // counts per tick come from a multiply; latch them with the period
        ctrl.lat_tick   = (state_reg == ST_WAIT_PERIOD) && stat.div_done;
        ctrl.load_in    = (state_reg == ST_IDLE) && in_valid;
        ctrl.mul_en     = (state_reg == ST_MUL);
        ctrl.finish     = (state_reg == ST_FIN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_DIV_PERIOD:  state_next = ST_WAIT_PERIOD;
            ST_WAIT_PERIOD: if (stat.div_done) state_next = ST_IDLE;
            ST_IDLE:        if (in_valid) state_next = ST_MUL;
            ST_MUL:         state_next = ST_FIN;
            ST_FIN:         if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_DIV_PERIOD;
        endcase
        // a new clock frequency invalidates both derived periods
        if (cfg_wr)
        begin
            state_next = ST_DIV_PERIOD;
        end

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DIV_PERIOD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
